FILE: design/neighbour_address_cache_with_aging_assert.svh
// assertion macros for the neighbour address cache checker
`ifndef NEIGHBOUR_ADDRESS_CACHE_WITH_AGING_ASSERT_SVH
`define NEIGHBOUR_ADDRESS_CACHE_WITH_AGING_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NAC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nac check failed");

// next-cycle implication, disabled during reset
`define NAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nac check failed");

`endif

FILE: design/nac_pkg.sv
// shared types, constants and helpers for the neighbour address cache
package nac_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [15:0] LIFETIME_RESET = 16'd300;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    RES_PRESENT = 3'd0,
    RES_ADDED   = 3'd1,
    RES_FULL    = 3'd2,
    RES_HIT     = 3'd3,
    RES_MISS    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } scan_state_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  port;
    logic [47:0] mac;
    logic [7:0]  address;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  port;
    logic [47:0] mac;
    logic [7:0]  address;
    logic        op;
  } req_t;

  // status in the lowest bits, port in the highest
  typedef struct packed {
    logic [7:0]  port;
    logic [47:0] mac;
    logic [3:0]  index;
    status_t     status;
  } result_t;

  // low four bits of a table index, zero extended for small tables
  function automatic logic [3:0] index_field(logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] wide;
    wide = {4'b0, idx};
    return wide[3:0];
  endfunction

endpackage

FILE: design/neighbour_address_cache_with_aging.sv
// neighbour address cache: top level with lifetime register and output register
// sequence: accept to result valid is a read-ahead, one evaluation per table entry, a write
//   for an insert, then the handoff; no write otherwise, and the scan stops at a matching entry
// flow: one request in flight, next accept the cycle after handoff
// reset: every entry reads as cleared at once (per-entry valid bits, no clearing pass),
//   entry lifetime returns to 300 seconds, no result pending
module neighbour_address_cache_with_aging
  import nac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // node_address[7:0], mac_in[55:8], port_in[63:56],
                                 // now_seconds[95:64]
  input  logic        s_tuser,   // op: 0 update, 1 lookup
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // status[2:0], entry_index[6:3], mac_out[54:7],
                                 // port_out[62:55], zero pad[63]
  // lifetime register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] entry_lifetime;
  req_t        req;
  logic        res_valid;
  logic        res_ready;
  result_t     res;
  result_t     out_res;

  // lifetime register, writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_lifetime <= LIFETIME_RESET;
    end else if (cfg_valid) begin
      entry_lifetime <= cfg_data;
    end
  end

  // unpack the request fields
  assign req = '{now: s_tdata[95:64], port: s_tdata[63:56], mac: s_tdata[55:8],
                 address: s_tdata[7:0], op: s_tuser};

  nac_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .lifetime  (entry_lifetime),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: the scan engine hands off and takes the next request
  // while the result waits here for the consumer
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res};

endmodule

FILE: design/nac_ram.sv
// generic single-write, single-read ram with registered read data
module nac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/nac_scan.sv
// table scan engine: sequencer, entry evaluation, valid bits and table ram
module nac_scan
  import nac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  input  logic [15:0] lifetime,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  scan_state_t state, state_next;

  req_t               cur;
  logic [CNT_W-1:0]   rd_cnt;
  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  logic               vld_q;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic [TABLE_ENTRIES-1:0] valid;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  entry_t             wr_entry;

  entry_t             entry;
  logic [31:0]        ev_age;
  logic               ev_zero;
  logic               ev_free;
  logic               ev_match;
  logic               ev_stop;
  logic               ev_last;
  logic               any_free;
  logic               is_lookup;

  assign rd_en   = (state == ST_SCAN) && (rd_cnt < ENTRIES_CNT);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  assign wr_entry = '{stamp: cur.now, port: cur.port, mac: cur.mac, address: cur.address};

  nac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entry under evaluation; never-written or cleared entries read as zero
  assign entry     = vld_q ? entry_t'(rd_data) : '0;
  assign is_lookup = (cur.op == OP_LOOKUP);
  assign ev_age    = cur.now - entry.stamp;
  assign ev_zero   = (entry.stamp == 32'd0);
  assign ev_free   = ev_zero || ((cur.now >= entry.stamp) && (ev_age > {16'd0, lifetime}));
  assign ev_match  = (entry.address == cur.address);
  assign ev_stop   = ev_valid && ev_match && (is_lookup || !ev_free);
  assign ev_last   = ev_valid && (ev_idx == LAST_IDX);
  assign any_free  = have_free || (ev_valid && ev_free && !is_lookup);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ev_stop) begin
          state_next = ST_DONE;
        end else if (ev_last) begin
          state_next = (!is_lookup && any_free) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // scan pointer and evaluation pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      ev_valid  <= 1'b0;
      vld_q     <= 1'b0;
      have_free <= 1'b0;
    end else if (state == ST_IDLE && req_valid) begin
      rd_cnt    <= '0;
      ev_valid  <= 1'b0;
      have_free <= 1'b0;
    end else if (state == ST_SCAN) begin
      ev_valid <= rd_en;
      if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
        vld_q  <= valid[rd_addr];
      end
      if (ev_valid && !is_lookup && ev_free && !have_free) begin
        have_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cur <= req;
    end
    if (state == ST_SCAN) begin
      if (rd_en) begin
        ev_idx <= rd_addr;
      end
      if (ev_valid && !is_lookup && ev_free && !have_free) begin
        free_idx <= ev_idx;
      end
      if (ev_stop) begin
        if (is_lookup) begin
          res <= '{port: entry.port, mac: entry.mac, index: index_field(ev_idx),
                   status: RES_HIT};
        end else begin
          res <= '{port: 8'd0, mac: 48'd0, index: index_field(ev_idx),
                   status: RES_PRESENT};
        end
      end else if (ev_last) begin
        if (is_lookup) begin
          res <= '{port: 8'd0, mac: 48'd0, index: 4'd0, status: RES_MISS};
        end else if (any_free) begin
          res <= '{port: 8'd0, mac: 48'd0,
                   index: index_field(have_free ? free_idx : ev_idx),
                   status: RES_ADDED};
        end else begin
          res <= '{port: 8'd0, mac: 48'd0, index: 4'd0, status: RES_FULL};
        end
      end
    end
  end

  // valid bits: cleared free entries with a zero stamp, set on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == ST_SCAN && ev_valid && !is_lookup && ev_zero) begin
      valid[ev_idx] <= 1'b0;
    end else if (wr_en) begin
      valid[free_idx] <= 1'b1;
    end
  end

endmodule

FILE: design/nac_checker.sv
// port-level checker for the neighbour address cache, bound to the top level
`include "neighbour_address_cache_with_aging_assert.svh"

module nac_checker
  import nac_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic no_payload;

  assign no_payload = (m_tdata[54:7] == 48'd0) && (m_tdata[62:55] == 8'd0);

  // a stalled result holds
  `NAC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one request in flight: no new request the cycle after one is taken
  `NAC_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // only a lookup hit carries mac and port
  `NAC_ASSERT_SAME(a_payload_on_hit, clk, rst,
                   m_tvalid && (m_tdata[2:0] != RES_HIT), no_payload)

  // full table and lookup miss report index zero and a known status code
  `NAC_ASSERT_SAME(a_index_zero, clk, rst,
                   m_tvalid && ((m_tdata[2:0] == RES_FULL) || (m_tdata[2:0] == RES_MISS)),
                   m_tdata[6:3] == 4'd0)

  `NAC_ASSERT_SAME(a_status_code, clk, rst, m_tvalid, m_tdata[2:0] <= RES_MISS)

endmodule

bind neighbour_address_cache_with_aging nac_checker u_nac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/neighbour_cache_checker.sv
// checker for the neighbour address cache: shadow table, expected results, compare
`timescale 1ns / 1ps

module neighbour_cache_checker
  import nac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,   // node_address[7:0], mac_in[55:8], port_in[63:56],
                                 // now_seconds[95:64]
  input  logic        s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // status[2:0], entry_index[6:3], mac_out[54:7],
                                 // port_out[62:55]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          results_due
);

  // shadow copy of the table and the lifetime register
  logic [7:0]  shadow_addr  [TABLE_ENTRIES];
  logic [47:0] shadow_mac   [TABLE_ENTRIES];
  logic [7:0]  shadow_port  [TABLE_ENTRIES];
  logic [31:0] shadow_stamp [TABLE_ENTRIES];
  logic [15:0] shadow_lifetime;

  result_t due_results[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 100)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  // works out the answer to one request and applies it to the shadow table
  task automatic resolve_request(input req_t rq, output result_t res);
    logic found_free;
    int   free_slot;
    logic stale;
    res = '{port: 8'd0, mac: 48'd0, index: 4'd0, status: RES_MISS};
    found_free = 1'b0;
    free_slot = 0;
    if (rq.op == OP_LOOKUP) begin
      // no age check, cleared entries match address zero
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (shadow_addr[i] == rq.address) begin
          res.status = RES_HIT;
          res.index  = 4'(i);
          res.mac    = shadow_mac[i];
          res.port   = shadow_port[i];
          return;
        end
      end
      return;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      stale = (shadow_stamp[i] == 32'd0) ||
              ((rq.now >= shadow_stamp[i]) &&
               ((rq.now - shadow_stamp[i]) > {16'd0, shadow_lifetime}));
      if (stale) begin
        if (shadow_stamp[i] == 32'd0) begin
          shadow_addr[i] = 8'd0;
          shadow_mac[i]  = 48'd0;
          shadow_port[i] = 8'd0;
        end
        if (!found_free) begin
          found_free = 1'b1;
          free_slot  = i;
        end
      end else if (shadow_addr[i] == rq.address) begin
        res.status = RES_PRESENT;
        res.index  = 4'(i);
        return;
      end
    end
    if (!found_free) begin
      res.status = RES_FULL;
      return;
    end
    shadow_addr[free_slot]  = rq.address;
    shadow_mac[free_slot]   = rq.mac;
    shadow_port[free_slot]  = rq.port;
    shadow_stamp[free_slot] = rq.now;
    res.status = RES_ADDED;
    res.index  = 4'(free_slot);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    req_t    rq;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        shadow_addr[i]  = 8'd0;
        shadow_mac[i]   = 48'd0;
        shadow_port[i]  = 8'd0;
        shadow_stamp[i] = 32'd0;
      end
      shadow_lifetime = LIFETIME_RESET;
      due_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 64'd0);
        end else begin
          want = due_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.index != want.index)
            report_mismatch("entry_index", 64'(got.index), 64'(want.index));
          if (got.mac != want.mac)
            report_mismatch("mac_out", 64'(got.mac), 64'(want.mac));
          if (got.port != want.port)
            report_mismatch("port_out", 64'(got.port), 64'(want.port));
        end
      end
      if (cfg_valid && cfg_ready)
        shadow_lifetime = cfg_data;
      if (s_tvalid && s_tready) begin
        rq = {s_tdata, s_tuser};
        resolve_request(rq, want);
        due_results.push_back(want);
      end
    end
    results_due <= due_results.size();
  end

endmodule

FILE: test/tb_neighbour_address_cache_with_aging.sv
// testbench top for the neighbour address cache: stimulus, idling, watchdog, verdict
`timescale 1ns / 1ps

module tb_neighbour_address_cache_with_aging;
  import nac_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 80;
  localparam int POOL_SIZE = 20;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;    // node_address[7:0], mac_in[55:8], port_in[63:56],
                                // now_seconds[95:64]
  logic        s_tuser = 1'b0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // status[2:0], entry_index[6:3], mac_out[54:7],
                                // port_out[62:55]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int results_due;
  int send_gap_pct = 0;   // chance of an idle cycle before each request
  int stall_pct = 0;      // chance of holding off a result in a cycle
  int quiet_cycles = 0;

  neighbour_address_cache_with_aging dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  neighbour_cache_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random hold-off on the result stream
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: cycles with no request, result or register write accepted
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL neighbour_address_cache_with_aging");
      $finish;
    end
  end

  // one request, with an optional random gap in front of it
  task automatic send_request(input logic op, input logic [7:0] addr,
                              input logic [47:0] mac, input logic [7:0] port,
                              input logic [31:0] now);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, port, mac, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [15:0] seconds);
    cfg_valid <= 1'b1;
    cfg_data  <= seconds;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] lifetimes [PHASES];
    int          gap_by_mode [4];
    int          stall_by_mode [4];
    logic [7:0]  addr_pool [POOL_SIZE];
    logic [31:0] cur_now;
    logic [31:0] stamp;
    logic [7:0]  addr;
    logic        op;
    int          pick;
    int          lifetime;

    lifetimes     = '{16'd0, 16'hFFFF, 16'd12, 16'd300, 16'd1, 16'd2500};
    // no idling, sender idle 80, receiver stall 80, both 24
    gap_by_mode   = '{0, 80, 0, 24};
    stall_by_mode = '{0, 0, 80, 24};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, lifetime still at its reset value of 300 seconds
    // cleared table: address zero hits entry 0 with zero mac and port
    send_request(OP_LOOKUP, 8'h00, 48'd0, 8'd0, 32'd0);
    send_request(OP_LOOKUP, 8'hFF, 48'd0, 8'd0, 32'd0);
    send_request(OP_UPDATE, 8'h11, 48'd0, 8'h00, 32'd10);
    send_request(OP_UPDATE, 8'hFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'd10);
    // same address while still live
    send_request(OP_UPDATE, 8'h11, 48'h1234_5678_9ABC, 8'h07, 32'd10);
    // time going backwards: entries stamped 10 stay live, entry written at time zero
    send_request(OP_UPDATE, 8'h5A, 48'hA5A5_A5A5_A5A5, 8'h5A, 32'd0);
    send_request(OP_LOOKUP, 8'h5A, 48'd0, 8'd0, 32'd0);
    // both early entries expired, the time-zero entry gets cleared by the scan
    send_request(OP_UPDATE, 8'h33, 48'h0000_0000_0001, 8'h01, 32'd400);
    send_request(OP_LOOKUP, 8'h5A, 48'd0, 8'd0, 32'd400);
    // lookup ignores age: expired entry still answers
    send_request(OP_LOOKUP, 8'hFF, 48'd0, 8'd0, 32'd400);
    send_request(OP_UPDATE, 8'hFF, 48'h8000_0000_0000, 8'h80, 32'd400);
    // age exactly equal to the lifetime is still live, one more second expires it
    send_request(OP_UPDATE, 8'h33, 48'd0, 8'd0, 32'd700);
    send_request(OP_UPDATE, 8'h33, 48'h5555_5555_5555, 8'h55, 32'd701);
    // top of the time range
    send_request(OP_UPDATE, 8'h80, 48'h8000_0000_0000, 8'h80, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 8'h80, 48'd0, 8'd0, 32'hFFFF_FFFF);

    cur_now = 32'd1000;
    for (int phase = 0; phase < PHASES; phase++) begin
      // register writes only with the block idle
      drain_results();
      write_lifetime(lifetimes[phase]);
      lifetime      = int'(lifetimes[phase]);
      send_gap_pct  = gap_by_mode[phase % 4];
      stall_pct     = stall_by_mode[phase % 4];
      for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = 8'($urandom_range(0, 255));

      repeat (PHASE_REQUESTS) begin
        // now and then let everything drain mid-phase
        if ($urandom_range(0, 99) < 2) drain_results();
        op = ($urandom_range(0, 99) < 40) ? OP_LOOKUP : OP_UPDATE;
        // mostly a small address set so that updates meet live entries
        pick = $urandom_range(0, 99);
        if (pick < 70) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 75) addr = 8'h00;
        else addr = 8'($urandom_range(0, 255));
        // time mostly creeps forward, sometimes leaps past the lifetime or anywhere
        pick = $urandom_range(0, 99);
        if (pick < 3) cur_now = $urandom();
        else if (pick < 8) cur_now = cur_now + $urandom_range(0, 2 * lifetime + 2);
        else cur_now = cur_now + $urandom_range(0, (lifetime >> 6) + 1);
        // rare time-zero writes that count as free at once
        stamp = ($urandom_range(0, 99) < 2) ? 32'd0 : cur_now;
        send_request(op, addr, {16'($urandom()), $urandom()}, 8'($urandom_range(0, 255)),
                     stamp);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS neighbour_address_cache_with_aging");
    end else begin
      $display("FAIL neighbour_address_cache_with_aging");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/nac_pkg.sv
design/nac_ram.sv
design/nac_scan.sv
design/neighbour_address_cache_with_aging.sv
design/nac_checker.sv
test/neighbour_cache_checker.sv
test/tb_neighbour_address_cache_with_aging.sv
